// ===== sv/cell_range_reference_parser_core_macros.svh =====
// Assertion macros shared by the range reference parser.
`ifndef CELL_RANGE_REFERENCE_PARSER_CORE_MACROS_SVH
`define CELL_RANGE_REFERENCE_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CRRP_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("range parser assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CRRP_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("range parser assertion failed");

`else

`define CRRP_ASSERT_SAME(label, clk, rst, cond, expr)
`define CRRP_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ===== sv/crrp_pkg.sv =====
package crrp_pkg;

   localparam int unsigned     MAX_COLS_DEF = 16384;
   localparam longint unsigned MAX_ROWS_DEF = 64'd1048576;

   localparam int CH_W  = 8;
   localparam int COL_W = 14;
   localparam int ROW_W = 20;

   localparam logic [CH_W-1:0] CH_COLON    = 8'h3A;
   localparam logic [CH_W-1:0] CH_ZERO     = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE     = 8'h39;
   localparam logic [CH_W-1:0] CH_UPPER_A  = 8'h41;
   localparam logic [CH_W-1:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [CH_W-1:0] CH_LOWER_A  = 8'h61;
   localparam logic [CH_W-1:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [CH_W-1:0] CASE_OFFSET = 8'h20;

   localparam int unsigned COL_RADIX = 26;
   localparam int unsigned ROW_RADIX = 10;

   typedef enum logic [2:0] {
      PH_FIRST_LETTER,
      PH_START_LETTERS,
      PH_START_DIGITS,
      PH_END_FIRST_LETTER,
      PH_END_LETTERS,
      PH_END_DIGITS,
      PH_TRAILING,
      PH_BAD
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic      overflow;
   } ctrl_type;

endpackage

// ===== sv/crrp_if.sv =====
interface crrp_req_if;
   logic                      valid;
   logic                      ready;
   logic [crrp_pkg::CH_W-1:0] ch;
   logic                      last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

interface crrp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [crrp_pkg::COL_W-1:0] start_col;
   logic [crrp_pkg::ROW_W-1:0] start_row;
   logic [crrp_pkg::COL_W-1:0] end_col;
   logic [crrp_pkg::ROW_W-1:0] end_row;
   logic                       ok;

   modport source (output valid, output start_col, output start_row, output end_col,
                   output end_row, output ok, input ready);
   modport sink   (input valid, input start_col, input start_row, input end_col,
                   input end_row, input ok, output ready);
endinterface

// ===== sv/crrp_step.sv =====
module crrp_step #(
   parameter int unsigned     MAX_COLS = crrp_pkg::MAX_COLS_DEF,
   parameter longint unsigned MAX_ROWS = crrp_pkg::MAX_ROWS_DEF,
   parameter int              CW       = $clog2(MAX_COLS + 1),
   parameter int              RW       = $clog2(MAX_ROWS)
) (
   input  logic [crrp_pkg::CH_W-1:0]  ch,
   input  crrp_pkg::ctrl_type         ctrl,
   input  logic [CW-1:0]              col_acc,
   input  logic [RW-1:0]              row_acc,
   input  logic [CW-1:0]              saved_col,
   input  logic [RW-1:0]              saved_row,
   output crrp_pkg::ctrl_type         ctrl_next,
   output logic [CW-1:0]              col_next,
   output logic [RW-1:0]              row_next,
   output logic                       save_start,
   output logic [crrp_pkg::COL_W-1:0] start_col,
   output logic [crrp_pkg::ROW_W-1:0] start_row,
   output logic [crrp_pkg::COL_W-1:0] end_col,
   output logic [crrp_pkg::ROW_W-1:0] end_row,
   output logic                       ok
);
   import crrp_pkg::*;

   localparam logic [CW+4:0] COL_LIMIT = (CW+5)'(MAX_COLS);
   localparam logic [RW+3:0] ROW_LIMIT = (RW+4)'(MAX_ROWS - 1);

   logic              is_lower;
   logic [CH_W-1:0]   up;
   logic              is_letter;
   logic              is_digit;
   logic              is_colon;
   logic [CW+4:0]     col_sum;
   logic [RW+3:0]     row_sum;
   logic              col_ovf;
   logic              row_ovf;
   logic              add_letter;
   logic              add_digit;
   logic              ovf_next;
   logic [CW-1:0]     end_col_zb;
   logic [CW+COL_W-1:0] start_col_wide;
   logic [CW+COL_W-1:0] end_col_wide;
   logic [RW+ROW_W-1:0] start_row_wide;
   logic [RW+ROW_W-1:0] end_row_wide;

   // Character classes; lower case letters fold onto upper case.
   always_comb begin
      is_lower  = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z);
      up        = is_lower ? ch - CASE_OFFSET : ch;
      is_letter = (up >= CH_UPPER_A) && (up <= CH_UPPER_Z);
      is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
      is_colon  = (ch == CH_COLON);
   end

   // One multiply-add per accumulator, checked against its limit.
   always_comb begin
      col_sum = (CW+5)'(col_acc) * (CW+5)'(COL_RADIX)
              + (CW+5)'(up - CH_UPPER_A) + (CW+5)'(1);
      row_sum = (RW+4)'(row_acc) * (RW+4)'(ROW_RADIX) + (RW+4)'(ch - CH_ZERO);
      col_ovf = col_sum > COL_LIMIT;
      row_ovf = row_sum > ROW_LIMIT;
   end

   // Next phase.
   always_comb begin
      ctrl_next.phase    = ctrl.phase;
      ctrl_next.overflow = ovf_next;
      unique case (ctrl.phase)
         PH_FIRST_LETTER:     ctrl_next.phase = is_letter ? PH_START_LETTERS : PH_BAD;
         PH_END_FIRST_LETTER: ctrl_next.phase = is_letter ? PH_END_LETTERS : PH_BAD;
         PH_START_LETTERS: begin
            if (is_digit) begin
               ctrl_next.phase = PH_START_DIGITS;
            end else if (!is_letter) begin
               ctrl_next.phase = PH_BAD;
            end
         end
         PH_END_LETTERS: begin
            if (is_digit) begin
               ctrl_next.phase = PH_END_DIGITS;
            end else if (!is_letter) begin
               ctrl_next.phase = PH_BAD;
            end
         end
         PH_START_DIGITS: begin
            if (is_colon) begin
               ctrl_next.phase = PH_END_FIRST_LETTER;
            end else if (!is_digit) begin
               ctrl_next.phase = PH_BAD;
            end
         end
         PH_END_DIGITS: begin
            if (!is_digit) begin
               ctrl_next.phase = PH_TRAILING;
            end
         end
         PH_TRAILING: ctrl_next.phase = PH_TRAILING;
         PH_BAD:      ctrl_next.phase = PH_BAD;
         default:     ctrl_next.phase = PH_BAD;
      endcase
   end

   // Accumulator updates.
   always_comb begin
      add_letter = 1'b0;
      add_digit  = 1'b0;
      save_start = 1'b0;
      case (ctrl.phase)
         PH_FIRST_LETTER, PH_END_FIRST_LETTER: add_letter = is_letter;
         PH_START_LETTERS, PH_END_LETTERS: begin
            add_letter = is_letter;
            add_digit  = !is_letter && is_digit;
         end
         PH_START_DIGITS: begin
            add_digit  = is_digit;
            save_start = !is_digit && is_colon;
         end
         PH_END_DIGITS: add_digit = is_digit;
         default: begin
            add_letter = 1'b0;
         end
      endcase

      ovf_next = ctrl.overflow || (add_letter && col_ovf) || (add_digit && row_ovf);
      col_next = col_acc;
      row_next = row_acc;
      if (save_start) begin
         col_next = '0;
         row_next = '0;
      end else if (add_letter && !col_ovf) begin
         col_next = col_sum[CW-1:0];
      end else if (add_digit && !row_ovf) begin
         row_next = row_sum[RW-1:0];
      end
   end

   // Result as seen after this byte.
   always_comb begin
      ok = ((ctrl_next.phase == PH_END_DIGITS) || (ctrl_next.phase == PH_TRAILING))
           && !ctrl_next.overflow;
      end_col_zb     = col_next - CW'(1);
      start_col_wide = {COL_W'(0), saved_col};
      end_col_wide   = {COL_W'(0), end_col_zb};
      start_row_wide = {ROW_W'(0), saved_row};
      end_row_wide   = {ROW_W'(0), row_next};
      start_col = ok ? start_col_wide[COL_W-1:0] : '0;
      start_row = ok ? start_row_wide[ROW_W-1:0] : '0;
      end_col   = ok ? end_col_wide[COL_W-1:0] : '0;
      end_row   = ok ? end_row_wide[ROW_W-1:0] : '0;
   end

endmodule

// ===== sv/cell_range_reference_parser_core.sv =====
// A byte is registered in the input stage at its transfer and is processed from there;
// the result of a last byte is registered in the result register, which drives the result channel.
// Throughput: one byte per cycle while the result register can take a last byte.
// Reset (synchronous, active high) empties both stages and returns the parser to
// expecting the first letter; each result also returns it there for the next text.
`include "cell_range_reference_parser_core_macros.svh"

module cell_range_reference_parser_core #(
   parameter int unsigned     MAX_COLS = crrp_pkg::MAX_COLS_DEF,
   parameter longint unsigned MAX_ROWS = crrp_pkg::MAX_ROWS_DEF
) (
   input logic        clock,
   input logic        reset,
   crrp_req_if.sink   req_bus,
   crrp_rsp_if.source rsp_bus
);
   import crrp_pkg::*;

   localparam int CW = $clog2(MAX_COLS + 1);
   localparam int RW = $clog2(MAX_ROWS);

   logic            s1_valid_ff, s1_valid_in;
   logic [CH_W-1:0] s1_ch_ff;
   logic            s1_last_ff;
   logic            s1_fire;
   logic            out_free;

   ctrl_type        ctrl_ff, ctrl_in, ctrl_step;
   logic [CW-1:0]   col_acc_ff, col_acc_in, col_step;
   logic [RW-1:0]   row_acc_ff, row_acc_in, row_step;
   logic [CW-1:0]   saved_col_ff;
   logic [RW-1:0]   saved_row_ff;
   logic            save_start;

   logic [COL_W-1:0] start_col, end_col;
   logic [ROW_W-1:0] start_row, end_row;
   logic             ok;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0] rsp_start_col_ff, rsp_end_col_ff;
   logic [ROW_W-1:0] rsp_start_row_ff, rsp_end_row_ff;
   logic             rsp_ok_ff;

   // A last byte may only leave the input stage when the result register can take it.
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_fire       = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_fire;
   assign s1_valid_in   = req_bus.valid || (s1_valid_ff && !s1_fire);

   crrp_step #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .CW       (CW),
      .RW       (RW)
   ) u_step (
      .ch         (s1_ch_ff),
      .ctrl       (ctrl_ff),
      .col_acc    (col_acc_ff),
      .row_acc    (row_acc_ff),
      .saved_col  (saved_col_ff),
      .saved_row  (saved_row_ff),
      .ctrl_next  (ctrl_step),
      .col_next   (col_step),
      .row_next   (row_step),
      .save_start (save_start),
      .start_col  (start_col),
      .start_row  (start_row),
      .end_col    (end_col),
      .end_row    (end_row),
      .ok         (ok)
   );

   always_comb begin
      ctrl_in    = ctrl_ff;
      col_acc_in = col_acc_ff;
      row_acc_in = row_acc_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            ctrl_in    = '{phase: PH_FIRST_LETTER, overflow: 1'b0};
            col_acc_in = '0;
            row_acc_in = '0;
         end else begin
            ctrl_in    = ctrl_step;
            col_acc_in = col_step;
            row_acc_in = row_step;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (s1_fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctrl_ff      <= '{phase: PH_FIRST_LETTER, overflow: 1'b0};
         col_acc_ff   <= '0;
         row_acc_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ctrl_ff      <= ctrl_in;
         col_acc_ff   <= col_acc_in;
         row_acc_ff   <= row_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_ch_ff   <= req_bus.ch;
         s1_last_ff <= req_bus.last;
      end
      if (s1_fire && save_start) begin
         saved_col_ff <= col_acc_ff - CW'(1);
         saved_row_ff <= row_acc_ff;
      end
      if (s1_fire && s1_last_ff) begin
         rsp_start_col_ff <= start_col;
         rsp_start_row_ff <= start_row;
         rsp_end_col_ff   <= end_col;
         rsp_end_row_ff   <= end_row;
         rsp_ok_ff        <= ok;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.start_col = rsp_start_col_ff;
   assign rsp_bus.start_row = rsp_start_row_ff;
   assign rsp_bus.end_col   = rsp_end_col_ff;
   assign rsp_bus.end_row   = rsp_end_row_ff;
   assign rsp_bus.ok        = rsp_ok_ff;

   `CRRP_ASSERT_SAME(a_failed_result_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff,
      rsp_start_col_ff == '0 && rsp_start_row_ff == '0
      && rsp_end_col_ff == '0 && rsp_end_row_ff == '0)
   `CRRP_ASSERT_NEXT(a_last_restarts, clock, reset, s1_fire && s1_last_ff,
      ctrl_ff.phase == PH_FIRST_LETTER && !ctrl_ff.overflow && col_acc_ff == '0 && row_acc_ff == '0)
   `CRRP_ASSERT_NEXT(a_last_gives_result, clock, reset, s1_fire && s1_last_ff, rsp_valid_ff)
   `CRRP_ASSERT_SAME(a_no_result_overwrite, clock, reset, rsp_valid_ff && !rsp_bus.ready,
      !(s1_fire && s1_last_ff))

endmodule
